### hw/rtl/assert_macros.svh
// assertion helpers for the flow tracker checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge out of reset
`define CHK_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("check failed");

// antecedent implies consequent on the next edge
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");

`endif

### hw/rtl/tfst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfst_pkg
// types and constants shared by the flow tracker modules
// ----------------------------------------------------------------------------
package tfst_pkg;

  localparam int FLOW_ENTRIES = 64;
  localparam int IDX_W = $clog2(FLOW_ENTRIES);
  localparam int CNT_W = $clog2(FLOW_ENTRIES + 1);

  typedef enum logic [2:0] {
    ST_NEW    = 3'd0,
    ST_SYN    = 3'd1,
    ST_SYNACK = 3'd2,
    ST_DATA   = 3'd3,
    ST_FIN    = 3'd4,
    ST_RESET  = 3'd5,
    ST_LATE   = 3'd6
  } tcp_st_t;

  localparam logic [1:0] DIR_UNKNOWN  = 2'd0;
  localparam logic [1:0] DIR_LOW_SRV  = 2'd1;
  localparam logic [1:0] DIR_HIGH_SRV = 2'd2;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic        syn_flag;
    logic        ack_flag;
    logic        fin_flag;
    logic        rst_flag;
    logic [31:0] timestamp;
  } pkt_in_t;

  typedef struct packed {
    logic [31:0] session_id;
    logic        new_session;
    logic [2:0]  client_state;
    logic [2:0]  server_state;
    logic [1:0]  server_side;
    logic        error_flag;
    logic [31:0] packet_count;
    logic [6:0]  evicted_count;
    logic        table_full;
  } pkt_out_t;

  // one flow record as held in a cell
  typedef struct packed {
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] ports;
    logic [2:0]  cli;
    logic [2:0]  srv;
    logic [1:0]  dir;
    logic        err;
    logic [31:0] cli_seq;
    logic [31:0] srv_seq;
    logic [31:0] srv_ack;
    logic [31:0] last;
    logic [31:0] num;
    logic [31:0] pkts;
  } flow_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_UPDATE,
    S_EVICT,
    S_OUT
  } fsm_t;

  // command from the sequencer to every cell
  typedef struct packed {
    logic       clear;    // never set by the sequencer; the cells ignore it
    logic       match;    // search only; cells always compare key, flag hit
    logic       remove;   // pull hit cell out, shift younger ones down
    logic       append;   // write record at the tail
    logic       evict;    // drop head, shift all down
    logic [CNT_W-1:0] len;
  } cell_cmd_t;

  // transition of one flow record by one packet
  function automatic flow_t flow_step(flow_t f, pkt_in_t p, logic [31:0] lo);
    logic src_low, from_srv, both_fin, syn, ackf, fin, rst;
    flow_t n;
    n = f;
    syn = p.syn_flag; ackf = p.ack_flag; fin = p.fin_flag; rst = p.rst_flag;
    src_low = (p.src_addr == lo);
    n.last = p.timestamp;
    if (f.cli == ST_NEW && f.srv == ST_NEW) begin
      if (syn && !(ackf || fin || rst)) begin
        n.dir = src_low ? DIR_HIGH_SRV : DIR_LOW_SRV;
        n.cli = ST_SYN; n.cli_seq = p.seq_num;
      end else if (syn && ackf && !(fin || rst)) begin
        n.dir = src_low ? DIR_LOW_SRV : DIR_HIGH_SRV;
        n.srv = ST_SYNACK; n.srv_seq = p.seq_num; n.srv_ack = p.ack_num;
      end else if (rst) begin
        n.dir = src_low ? DIR_LOW_SRV : DIR_HIGH_SRV;
        n.srv = ST_RESET; n.srv_seq = p.seq_num; n.srv_ack = p.ack_num;
      end else if (fin) begin
        n.dir = src_low ? DIR_HIGH_SRV : DIR_LOW_SRV;
        n.cli = ST_DATA; n.cli_seq = p.seq_num;
      end else begin
        n.dir = src_low ? DIR_HIGH_SRV : DIR_LOW_SRV;
        n.cli = ST_DATA; n.srv = ST_DATA; n.cli_seq = p.seq_num;
      end
    end else begin
      from_srv = (f.dir == DIR_LOW_SRV && p.src_addr == lo) ||
                 (f.dir == DIR_HIGH_SRV && p.src_addr == f.hi);
      both_fin = (f.cli == ST_FIN && f.srv == ST_FIN);
      if (from_srv) begin
        if (both_fin && !(fin || syn || rst)) begin
          n.cli = ST_LATE; n.srv = ST_LATE;
        end else if (syn && ackf && !(rst || fin)) begin
          if (f.srv == ST_NEW && f.cli == ST_SYN) begin
            n.srv = ST_SYNACK; n.srv_seq = p.seq_num; n.srv_ack = p.ack_num;
            if (p.ack_num != f.cli_seq + 32'd1) n.err = 1'b1;
          end else if (f.srv == ST_SYNACK) begin
            if (f.srv_seq != p.seq_num || f.srv_ack != p.ack_num) n.err = 1'b1;
          end
        end else if (rst) begin
          n.srv = ST_RESET; n.srv_seq = p.seq_num; n.srv_ack = p.ack_num;
        end else if (fin) begin
          n.srv = ST_FIN; n.srv_seq = p.seq_num; n.srv_ack = p.ack_num;
        end else if (f.srv == ST_SYNACK && f.cli == ST_DATA) begin
          n.srv = ST_DATA; n.srv_seq = p.seq_num; n.srv_ack = p.ack_num;
        end else if (f.srv == ST_DATA) begin
          n.srv_seq = p.seq_num; n.srv_ack = p.ack_num;
        end else begin
          n.err = 1'b1;
        end
      end else begin
        if (both_fin && !(fin || syn || rst)) begin
          n.cli = ST_LATE; n.srv = ST_LATE;
        end else if (!(fin || rst)) begin
          if (f.cli == ST_SYN && f.srv == ST_SYNACK) begin
            n.cli = ST_DATA; n.cli_seq = p.seq_num;
          end else if (f.cli == ST_DATA) begin
            n.cli_seq = p.seq_num;
          end
        end else if (rst) begin
          n.cli = ST_RESET;
        end else begin
          n.cli = ST_FIN;
        end
      end
    end
    if (f.pkts != 32'hFFFF_FFFF) n.pkts = f.pkts + 32'd1;
    return n;
  endfunction

endpackage

### hw/rtl/tfst_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfst_cell
// one slot of the age-ordered flow chain; position 0 is the oldest flow
// ----------------------------------------------------------------------------
module tfst_cell import tfst_pkg::*; (
  input  logic             clk,
  input  logic [IDX_W-1:0] pos,
  input  cell_cmd_t        cmd,
  input  logic [95:0]      key,
  input  flow_t            app_rec,
  input  flow_t            up_rec,   // record of the next younger cell
  input  logic             up_hit_before, // hit at or below this cell
  output flow_t            rec,
  output logic             hit
);

  flow_t rec_r, rec_nxt;
  logic  occ;

  assign occ = ({1'b0, pos} < cmd.len);
  assign rec = rec_r;
  assign hit = occ && ({rec_r.lo, rec_r.hi, rec_r.ports} == key);

  always_comb begin
    rec_nxt = rec_r;
    if (cmd.remove && up_hit_before) rec_nxt = up_rec;
    if (cmd.evict) rec_nxt = up_rec;
    if (cmd.append && {1'b0, pos} == cmd.len) rec_nxt = app_rec;
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

endmodule

### hw/rtl/tfst_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfst_ctrl
// packet sequencer: search, update, append, eviction sweep and result beat
// ----------------------------------------------------------------------------
module tfst_ctrl import tfst_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  pkt_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output pkt_out_t    out_data,
  input  logic [15:0] timeout,
  input  logic        any_hit,
  input  flow_t       hit_rec,
  input  flow_t       head_rec,
  output cell_cmd_t   cmd,
  output logic [95:0] key,
  output flow_t       app_rec
);

  fsm_t             state_r, state_nxt;
  logic [CNT_W-1:0] len_r, len_nxt;
  logic [31:0]      fnum_r, fnum_nxt;
  pkt_in_t          pkt_r;
  pkt_out_t         res_r, res_nxt;
  flow_t            upd_r, upd_nxt;
  logic [6:0]       evc_r, evc_nxt;
  logic [31:0]      lo, hi, ports;
  logic             swap;
  flow_t            base;
  logic [32:0]      expire;

  assign swap  = !(pkt_r.src_addr < pkt_r.dst_addr);
  assign lo    = swap ? pkt_r.dst_addr : pkt_r.src_addr;
  assign hi    = swap ? pkt_r.src_addr : pkt_r.dst_addr;
  assign ports = swap ? {pkt_r.dst_port, pkt_r.src_port} : {pkt_r.src_port, pkt_r.dst_port};
  assign key   = {lo, hi, ports};
  assign app_rec = upd_r;
  assign expire = {1'b0, head_rec.last} + {17'd0, timeout};

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data  = res_r;

  always_comb begin
    state_nxt = state_r;
    len_nxt   = len_r;
    fnum_nxt  = fnum_r;
    res_nxt   = res_r;
    upd_nxt   = upd_r;
    evc_nxt   = evc_r;
    cmd       = '0;
    cmd.len   = len_r;
    base      = hit_rec;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_SEARCH;
      end
      S_SEARCH: begin
        cmd.match = 1'b1;
        if (!any_hit) begin
          base = '0;
          base.lo = lo; base.hi = hi; base.ports = ports;
          base.num = fnum_r;
        end
        if (!any_hit && len_r == CNT_W'(FLOW_ENTRIES)) begin
          res_nxt = '0;
          res_nxt.table_full = 1'b1;
          state_nxt = S_OUT;
        end else begin
          upd_nxt = flow_step(base, pkt_r, lo);
          if (!any_hit) fnum_nxt = fnum_r + 32'd1;
          res_nxt.session_id   = upd_nxt.num;
          res_nxt.new_session  = !any_hit;
          res_nxt.client_state = upd_nxt.cli;
          res_nxt.server_state = upd_nxt.srv;
          res_nxt.server_side  = upd_nxt.dir;
          res_nxt.error_flag   = upd_nxt.err;
          res_nxt.packet_count = upd_nxt.pkts;
          res_nxt.table_full   = 1'b0;
          cmd.remove = any_hit;
          if (any_hit) len_nxt = len_r - CNT_W'(1);
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.append = 1'b1;
        len_nxt = len_r + CNT_W'(1);
        evc_nxt = '0;
        state_nxt = S_EVICT;
      end
      S_EVICT: begin
        // newest flow is the current one, never dropped here
        if (len_r > CNT_W'(1) && expire < {1'b0, pkt_r.timestamp}) begin
          cmd.evict = 1'b1;
          len_nxt = len_r - CNT_W'(1);
          evc_nxt = evc_r + 7'd1;
        end else begin
          res_nxt.evicted_count = evc_r;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r   <= '0;
      fnum_r  <= '0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      fnum_r  <= fnum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) pkt_r <= in_data;
    res_r <= res_nxt;
    upd_r <= upd_nxt;
    evc_r <= evc_nxt;
  end

endmodule

### hw/rtl/tcp_flow_state_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_flow_state_tracker
// tcp connection tracker over an age-ordered chain of flow cells
//
// in_*  : one packet header per beat (valid/ready), pkt_in_t
// out_* : one result per packet (valid/ready), pkt_out_t
// cfg_* : idle timeout write, seconds, always ready; write only with no packet
//         in flight
// one packet at a time: accept, search, update/append, then an eviction sweep
// that drops the oldest flow while it has timed out and more than one flow is
// held, then the result beat. a full table skips update and sweep and goes
// straight from search to the result beat.
// reset empties the chain, zeroes the flow numbering, timeout back to 60
// a stalled result holds its beat; no new packet is taken until it leaves
// ----------------------------------------------------------------------------
module tcp_flow_state_tracker import tfst_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  pkt_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output pkt_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_idle_timeout
);

  logic [15:0] timeout_r;
  cell_cmd_t   cmd;
  logic [95:0] key;
  flow_t       app_rec, hit_rec;
  flow_t       recs [FLOW_ENTRIES+1];
  logic        hits [FLOW_ENTRIES];
  logic        hb   [FLOW_ENTRIES+1];
  logic        any_hit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) timeout_r <= 16'd60;
    else if (cfg_valid) timeout_r <= cfg_idle_timeout;
  end

  assign recs[FLOW_ENTRIES] = '0;
  assign hb[0] = 1'b0;

  for (genvar g = 0; g < FLOW_ENTRIES; g++) begin : g_cell
    tfst_cell u_cell (
      .clk(clk), .pos(IDX_W'(g)), .cmd(cmd), .key(key), .app_rec(app_rec),
      .up_rec(recs[g+1]), .up_hit_before(hb[g] | hits[g]),
      .rec(recs[g]), .hit(hits[g])
    );
    assign hb[g+1] = hb[g] | hits[g];
  end

  assign any_hit = hb[FLOW_ENTRIES];

  always_comb begin
    hit_rec = '0;
    for (int j = 0; j < FLOW_ENTRIES; j++) begin
      if (hits[j]) hit_rec = hit_rec | recs[j];
    end
  end

  tfst_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .timeout(timeout_r), .any_hit(any_hit), .hit_rec(hit_rec),
    .head_rec(recs[0]), .cmd(cmd), .key(key), .app_rec(app_rec)
  );

endmodule

### hw/rtl/tfst_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfst_checker
// port-level checks on the flow tracker
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module tfst_checker import tfst_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input pkt_out_t out_data
);

  `CHK_ALWAYS(a_one_side, clk, rst_n, !(in_ready && out_valid))
  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  `CHK_ALWAYS(a_full_clean, clk, rst_n,
    !(out_valid && out_data.table_full) || (out_data.packet_count == 32'd0))
  `CHK_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

bind tcp_flow_state_tracker tfst_checker u_tfst_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

### bench/tcp_flow_state_tracker_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_flow_state_tracker_chk
// watches the packet, result and timeout channels of the flow tracker, keeps
// its own flow table in age order, predicts the result of every accepted
// packet and compares each result beat field by field with the oldest one
// ----------------------------------------------------------------------------
module tcp_flow_state_tracker_chk import tfst_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  pkt_in_t     in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  pkt_out_t    out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_idle_timeout,
  output int          failures,
  output int          outstanding
);

  logic        fl_used  [FLOW_ENTRIES];
  logic [31:0] fl_lo    [FLOW_ENTRIES];
  logic [31:0] fl_hi    [FLOW_ENTRIES];
  logic [31:0] fl_ports [FLOW_ENTRIES];
  tcp_st_t     fl_cli   [FLOW_ENTRIES];
  tcp_st_t     fl_srv   [FLOW_ENTRIES];
  logic [1:0]  fl_side  [FLOW_ENTRIES];
  logic        fl_err   [FLOW_ENTRIES];
  logic [31:0] fl_cseq  [FLOW_ENTRIES];
  logic [31:0] fl_sseq  [FLOW_ENTRIES];
  logic [31:0] fl_sack  [FLOW_ENTRIES];
  logic [31:0] fl_last  [FLOW_ENTRIES];
  logic [31:0] fl_num   [FLOW_ENTRIES];
  logic [31:0] fl_pkts  [FLOW_ENTRIES];
  int          lru_list [$];
  logic [31:0] flow_counter;
  logic [15:0] idle_limit;
  pkt_out_t    expected_results [$];

  function automatic pkt_out_t track_packet(pkt_in_t p);
    logic [31:0] lo, hi, ports;
    logic syn, ackf, fin, rst, src_low, from_srv, both_fin;
    int e, h;
    int gone;
    pkt_out_t r;
    r = '0;
    e = -1;
    gone = 0;
    syn = p.syn_flag; ackf = p.ack_flag; fin = p.fin_flag; rst = p.rst_flag;
    if (p.src_addr < p.dst_addr) begin
      lo = p.src_addr; hi = p.dst_addr; ports = {p.src_port, p.dst_port};
    end else begin
      lo = p.dst_addr; hi = p.src_addr; ports = {p.dst_port, p.src_port};
    end
    for (int i = 0; i < FLOW_ENTRIES; i++)
      if (e < 0 && fl_used[i] && fl_lo[i] == lo && fl_hi[i] == hi && fl_ports[i] == ports)
        e = i;
    if (e < 0) begin
      for (int i = 0; i < FLOW_ENTRIES; i++)
        if (e < 0 && !fl_used[i]) e = i;
      if (e < 0) begin
        r.table_full = 1'b1;
        return r;
      end
      r.new_session = 1'b1;
      fl_used[e] = 1'b1;
      fl_lo[e] = lo; fl_hi[e] = hi; fl_ports[e] = ports;
      fl_cli[e] = ST_NEW; fl_srv[e] = ST_NEW;
      fl_side[e] = DIR_UNKNOWN; fl_err[e] = 1'b0;
      fl_cseq[e] = '0; fl_sseq[e] = '0; fl_sack[e] = '0; fl_pkts[e] = '0;
      fl_num[e] = flow_counter;
      flow_counter = flow_counter + 32'd1;
    end
    fl_last[e] = p.timestamp;
    for (int i = 0; i < lru_list.size(); i++)
      if (lru_list[i] == e) begin
        lru_list.delete(i);
        break;
      end
    lru_list.push_back(e);

    src_low = (p.src_addr == lo);
    if (fl_cli[e] == ST_NEW && fl_srv[e] == ST_NEW) begin
      if (syn && !(ackf || fin || rst)) begin
        fl_side[e] = src_low ? DIR_HIGH_SRV : DIR_LOW_SRV;
        fl_cli[e] = ST_SYN; fl_cseq[e] = p.seq_num;
      end else if (syn && ackf && !(fin || rst)) begin
        fl_side[e] = src_low ? DIR_LOW_SRV : DIR_HIGH_SRV;
        fl_srv[e] = ST_SYNACK; fl_sseq[e] = p.seq_num; fl_sack[e] = p.ack_num;
      end else if (rst) begin
        fl_side[e] = src_low ? DIR_LOW_SRV : DIR_HIGH_SRV;
        fl_srv[e] = ST_RESET; fl_sseq[e] = p.seq_num; fl_sack[e] = p.ack_num;
      end else if (fin) begin
        fl_side[e] = src_low ? DIR_HIGH_SRV : DIR_LOW_SRV;
        fl_cli[e] = ST_DATA; fl_cseq[e] = p.seq_num;
      end else begin
        fl_side[e] = src_low ? DIR_HIGH_SRV : DIR_LOW_SRV;
        fl_cli[e] = ST_DATA; fl_srv[e] = ST_DATA; fl_cseq[e] = p.seq_num;
      end
    end else begin
      from_srv = (fl_side[e] == DIR_LOW_SRV && p.src_addr == lo) ||
                 (fl_side[e] == DIR_HIGH_SRV && p.src_addr == hi);
      both_fin = (fl_cli[e] == ST_FIN && fl_srv[e] == ST_FIN);
      if (from_srv) begin
        if (both_fin && !(fin || syn || rst)) begin
          fl_cli[e] = ST_LATE; fl_srv[e] = ST_LATE;
        end else if (syn && ackf && !(rst || fin)) begin
          if (fl_srv[e] == ST_NEW && fl_cli[e] == ST_SYN) begin
            fl_srv[e] = ST_SYNACK; fl_sseq[e] = p.seq_num; fl_sack[e] = p.ack_num;
            if (p.ack_num != fl_cseq[e] + 32'd1) fl_err[e] = 1'b1;
          end else if (fl_srv[e] == ST_SYNACK) begin
            if (fl_sseq[e] != p.seq_num || fl_sack[e] != p.ack_num) fl_err[e] = 1'b1;
          end
        end else if (rst) begin
          fl_srv[e] = ST_RESET; fl_sseq[e] = p.seq_num; fl_sack[e] = p.ack_num;
        end else if (fin) begin
          fl_srv[e] = ST_FIN; fl_sseq[e] = p.seq_num; fl_sack[e] = p.ack_num;
        end else if (fl_srv[e] == ST_SYNACK && fl_cli[e] == ST_DATA) begin
          fl_srv[e] = ST_DATA; fl_sseq[e] = p.seq_num; fl_sack[e] = p.ack_num;
        end else if (fl_srv[e] == ST_DATA) begin
          fl_sseq[e] = p.seq_num; fl_sack[e] = p.ack_num;
        end else begin
          fl_err[e] = 1'b1;
        end
      end else begin
        if (both_fin && !(fin || syn || rst)) begin
          fl_cli[e] = ST_LATE; fl_srv[e] = ST_LATE;
        end else if (!(fin || rst)) begin
          if (fl_cli[e] == ST_SYN && fl_srv[e] == ST_SYNACK) begin
            fl_cli[e] = ST_DATA; fl_cseq[e] = p.seq_num;
          end else if (fl_cli[e] == ST_DATA) begin
            fl_cseq[e] = p.seq_num;
          end
        end else if (rst) begin
          fl_cli[e] = ST_RESET;
        end else begin
          fl_cli[e] = ST_FIN;
        end
      end
    end
    if (fl_pkts[e] != 32'hFFFF_FFFF) fl_pkts[e] = fl_pkts[e] + 32'd1;

    r.session_id   = fl_num[e];
    r.client_state = fl_cli[e];
    r.server_state = fl_srv[e];
    r.server_side  = fl_side[e];
    r.error_flag   = fl_err[e];
    r.packet_count = fl_pkts[e];

    // idle flows drop off the old end, no wrap in the sum
    while (lru_list.size() > 0) begin
      h = lru_list[0];
      if (!(({1'b0, fl_last[h]} + {17'd0, idle_limit}) < {1'b0, p.timestamp})) break;
      fl_used[h] = 1'b0;
      void'(lru_list.pop_front());
      gone++;
    end
    r.evicted_count = gone[6:0];
    return r;
  endfunction

  task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    pkt_out_t exp_r;
    if (!rst_n) begin
      for (int i = 0; i < FLOW_ENTRIES; i++) fl_used[i] = 1'b0;
      lru_list.delete();
      expected_results.delete();
      flow_counter = '0;
      idle_limit = 16'd60;
      failures = 0;
    end else begin
      if (cfg_valid && cfg_ready) idle_limit = cfg_idle_timeout;
      if (in_valid && in_ready) expected_results.push_back(track_packet(in_data));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no packet waiting");
          failures++;
        end else begin
          exp_r = expected_results.pop_front();
          compare_field("session_id", exp_r.session_id, out_data.session_id);
          compare_field("new_session", 32'(exp_r.new_session),
                        32'(out_data.new_session));
          compare_field("client_state", 32'(exp_r.client_state),
                        32'(out_data.client_state));
          compare_field("server_state", 32'(exp_r.server_state),
                        32'(out_data.server_state));
          compare_field("server_side", 32'(exp_r.server_side),
                        32'(out_data.server_side));
          compare_field("error_flag", 32'(exp_r.error_flag), 32'(out_data.error_flag));
          compare_field("packet_count", exp_r.packet_count, out_data.packet_count);
          compare_field("evicted_count", 32'(exp_r.evicted_count),
                        32'(out_data.evicted_count));
          compare_field("table_full", 32'(exp_r.table_full), 32'(out_data.table_full));
        end
      end
    end
    outstanding = expected_results.size();
  end

endmodule

### bench/tcp_flow_state_tracker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_flow_state_tracker_tb
// drives packets from a pool of flows, mostly as full connections (syn,
// syn-ack, ack, data, fin both ways, late ack) with some noise, under several
// idle timeouts with random stalls on both channels; the checker predicts
// ----------------------------------------------------------------------------
module tcp_flow_state_tracker_tb;
  import tfst_pkg::*;

  localparam int POOL     = 96;
  localparam int WD_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  pkt_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  pkt_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_idle_timeout = 16'd0;
  int          failures;
  int          outstanding;
  bit          stalls_on = 1'b1;
  int          quiet_cycles = 0;

  logic [31:0] peer_a [POOL];
  logic [31:0] peer_b [POOL];
  logic [15:0] port_a [POOL];
  logic [15:0] port_b [POOL];
  int          conn_step [POOL];
  logic [31:0] cli_isn [POOL];
  logic [31:0] srv_isn [POOL];
  logic [31:0] clock_s = 32'd1000;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  tcp_flow_state_tracker dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_idle_timeout(cfg_idle_timeout)
  );

  tcp_flow_state_tracker_chk chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_idle_timeout(cfg_idle_timeout),
    .failures(failures), .outstanding(outstanding)
  );

  initial begin
    forever begin
      @(negedge clk);
      if (stalls_on && $urandom_range(0, 5) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 9) - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WD_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_packet(pkt_in_t p);
    @(negedge clk);
    if (stalls_on && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 9) - 1) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = p;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_and_set_timeout(logic [15:0] secs);
    @(negedge clk);
    in_valid = 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (100) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_idle_timeout = secs;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic pkt_in_t build_packet(int f, bit from_client, bit syn, bit ackf,
                                           bit fin, bit rst, logic [31:0] seq,
                                           logic [31:0] ack);
    pkt_in_t p;
    p.src_addr = from_client ? peer_a[f] : peer_b[f];
    p.dst_addr = from_client ? peer_b[f] : peer_a[f];
    p.src_port = from_client ? port_a[f] : port_b[f];
    p.dst_port = from_client ? port_b[f] : port_a[f];
    p.syn_flag = syn; p.ack_flag = ackf; p.fin_flag = fin; p.rst_flag = rst;
    p.seq_num = seq; p.ack_num = ack;
    p.timestamp = clock_s;
    return p;
  endfunction

  function automatic pkt_in_t next_in_connection(int f);
    pkt_in_t p;
    bit side;
    side = 1'($urandom_range(0, 1));
    case (conn_step[f])
      0: begin
        cli_isn[f] = $urandom;
        p = build_packet(f, 1, 1, 0, 0, 0, cli_isn[f], 0);
      end
      1: begin
        srv_isn[f] = $urandom;
        p = build_packet(f, 0, 1, 1, 0, 0, srv_isn[f],
                         ($urandom_range(0, 9) == 0) ? $urandom : cli_isn[f] + 32'd1);
      end
      2: p = build_packet(f, 1, 0, 1, 0, 0, cli_isn[f] + 32'd1, srv_isn[f] + 32'd1);
      3, 4, 5: p = build_packet(f, side, 0, 1'($urandom_range(0, 1)), 0, 0,
                                $urandom, $urandom);
      6: p = build_packet(f, 1, 0, 1, 1, 0, $urandom, $urandom);
      7: p = build_packet(f, 0, 0, 1, 1, 0, $urandom, $urandom);
      default: p = build_packet(f, side, 0, 1, 0, 0, $urandom, $urandom);
    endcase
    conn_step[f] = (conn_step[f] == 8) ? 0 : conn_step[f] + 1;
    return p;
  endfunction

  function automatic pkt_in_t noise_packet(int f);
    pkt_in_t p;
    logic [3:0] flags;
    flags = 4'($urandom);
    p = build_packet(f, 1'($urandom_range(0, 1)), flags[3], flags[2], flags[1], flags[0],
                     $urandom, $urandom);
    if ($urandom_range(0, 7) == 0) begin
      p.src_addr = $urandom; p.dst_addr = $urandom;
      p.src_port = 16'($urandom); p.dst_port = 16'($urandom);
    end
    return p;
  endfunction

  task automatic random_phase(int count, int max_step, int jump_odds);
    int f;
    repeat (count) begin
      if ($urandom_range(0, jump_odds) == 0) clock_s = clock_s + $urandom_range(50, 400);
      else clock_s = clock_s + $urandom_range(0, max_step);
      f = $urandom_range(0, POOL - 1);
      if ($urandom_range(0, 9) < 7) send_packet(next_in_connection(f));
      else send_packet(noise_packet(f));
    end
  endtask

  initial begin
    pkt_in_t p;
    for (int i = 0; i < POOL; i++) begin
      peer_a[i] = $urandom; peer_b[i] = $urandom;
      port_a[i] = 16'($urandom); port_b[i] = 16'($urandom);
      conn_step[i] = 0;
    end
    peer_a[0] = 32'h0000_0000; peer_b[0] = 32'hFFFF_FFFF;
    port_a[0] = 16'h0000;      port_b[0] = 16'hFFFF;
    peer_a[1] = 32'hFFFF_FFFF; peer_b[1] = 32'h0000_0000;
    port_a[1] = 16'hFFFF;      port_b[1] = 16'h0000;
    peer_a[2] = 32'h1234_5678; peer_b[2] = 32'h1234_5678;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // every flag combination on a fresh flow, then flows with edge values
    for (int k = 0; k < 16; k++) begin
      p = build_packet(10 + k, k[4] ^ 1'b1, k[3], k[2], k[1], k[0], $urandom, $urandom);
      send_packet(p);
    end
    send_packet(build_packet(2, 1, 1, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_packet(build_packet(2, 0, 1, 1, 0, 0, 32'h0, 32'h0));
    clock_s = 32'h0;
    send_packet(build_packet(0, 1, 1, 0, 0, 0, 32'hFFFF_FFFF, 32'h0));
    send_packet(build_packet(0, 0, 1, 1, 0, 0, 32'h0, 32'h0));
    send_packet(build_packet(1, 0, 0, 1, 0, 0, 32'h0, 32'hFFFF_FFFF));
    clock_s = 32'hFFFF_FFFF;
    send_packet(build_packet(1, 1, 0, 0, 1, 0, 32'h0, 32'h0));
    clock_s = 32'd5000;

    drain_and_set_timeout(16'hFFFF);
    random_phase(300, 3, 1000000);
    clock_s = clock_s + 32'd70000;
    drain_and_set_timeout(16'd0);
    random_phase(250, 2, 20);
    drain_and_set_timeout(16'd7);
    random_phase(300, 3, 30);
    clock_s = 32'hFFFF_FF00;
    drain_and_set_timeout(16'd300);
    random_phase(150, 4, 40);
    stalls_on = 1'b0;
    random_phase(130, 4, 40);

    @(negedge clk);
    in_valid = 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (100) @(posedge clk);
    if (failures == 0 && outstanding == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
